// ===== design/tkpd_pkg.sv =====
package tkpd_pkg;

    // Table and scaling constants of the estimator.
    localparam int ASIN_ENTRIES = 201;
    localparam int ASIN_HALF    = (ASIN_ENTRIES - 1) / 2;
    localparam int OPA_W        = 65;
    localparam int OPB_W        = 34;

    localparam logic signed [OPB_W-1:0] GRAV_NUM   = 34'sd1242;
    localparam logic signed [OPB_W-1:0] GYRO_NUM   = 34'sd2357;
    localparam logic signed [OPB_W-1:0] SCALE_DEN  = 34'sd10000;
    localparam logic signed [OPB_W-1:0] DT_DEN     = 34'sd200;
    localparam logic signed [OPB_W-1:0] NOISE_DEN  = 34'sd200000;
    localparam logic signed [OPB_W-1:0] MICRO_DEN  = 34'sd1000000;
    localparam logic signed [OPB_W-1:0] COV_MUL    = 34'sd1000;

    typedef enum logic [2:0] {
        REG_GRAVITY_OFFSET = 3'd0,
        REG_GYRO_OFFSET    = 3'd1,
        REG_ANGLE_ZERO     = 3'd2,
        REG_GAIN_P         = 3'd3,
        REG_GAIN_D         = 3'd4
    } tkpd_reg_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_GD_MUL, ST_GD_DIV, ST_MEAS_DIV, ST_WD_MUL, ST_WD_DIV,
        ST_ANG_DIV, ST_P00_MUL, ST_P00_DIV, ST_P01_DIV, ST_CHECK,
        ST_KA_MUL, ST_KA_DIV, ST_KB_MUL, ST_KB_DIV, ST_K11_MUL, ST_K11_DIV,
        ST_K10_MUL, ST_K10_DIV, ST_K01_MUL, ST_K01_DIV, ST_K00_MUL, ST_K00_DIV,
        ST_RATE, ST_DP_MUL, ST_DD_MUL, ST_DRV_DIV, ST_OUT
    } tkpd_state_t;

    typedef struct packed {
        logic                    start;
        logic                    is_div;
        logic                    rnd;
        logic signed [OPA_W-1:0] a;
        logic signed [OPB_W-1:0] b;
    } tkpd_arith_req_t;

    typedef struct packed {
        logic                    done;
        logic signed [OPA_W-1:0] value;
    } tkpd_arith_rsp_t;

    function automatic logic signed [31:0] sat32(input logic signed [OPA_W-1:0] v);
        logic signed [31:0] r;
        if (v > 65'sd2147483647)
            r = 32'sh7FFF_FFFF;
        else if (v < -65'sd2147483648)
            r = 32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic signed [39:0] sat40(input logic signed [OPA_W-1:0] v);
        logic signed [39:0] r;
        if (v > 65'sd549755813887)
            r = 40'sh7F_FFFF_FFFF;
        else if (v < -65'sd549755813888)
            r = 40'sh80_0000_0000;
        else
            r = v[39:0];
        return r;
    endfunction

    // Arcsine in micro-degrees for sine values 0.00 to 1.00 in steps of 0.01.
    function automatic logic [26:0] asin_micro(input logic [6:0] idx);
        logic [26:0] r;
        unique case (idx)
            7'd0:   r = 27'd0;        7'd1:   r = 27'd572967;   7'd2:   r = 27'd1145992;
            7'd3:   r = 27'd1719131;  7'd4:   r = 27'd2292443;  7'd5:   r = 27'd2865984;
            7'd6:   r = 27'd3439813;  7'd7:   r = 27'd4013987;  7'd8:   r = 27'd4588566;
            7'd9:   r = 27'd5163607;  7'd10:  r = 27'd5739170;  7'd11:  r = 27'd6315316;
            7'd12:  r = 27'd6892103;  7'd13:  r = 27'd7469592;  7'd14:  r = 27'd8047846;
            7'd15:  r = 27'd8626927;  7'd16:  r = 27'd9206896;  7'd17:  r = 27'd9787819;
            7'd18:  r = 27'd10369760; 7'd19:  r = 27'd10952784; 7'd20:  r = 27'd11536959;
            7'd21:  r = 27'd12122352; 7'd22:  r = 27'd12709033; 7'd23:  r = 27'd13297072;
            7'd24:  r = 27'd13886540; 7'd25:  r = 27'd14477512; 7'd26:  r = 27'd15070062;
            7'd27:  r = 27'd15664267; 7'd28:  r = 27'd16260205; 7'd29:  r = 27'd16857956;
            7'd30:  r = 27'd17457603; 7'd31:  r = 27'd18059230; 7'd32:  r = 27'd18662925;
            7'd33:  r = 27'd19268775; 7'd34:  r = 27'd19876874; 7'd35:  r = 27'd20487315;
            7'd36:  r = 27'd21100196; 7'd37:  r = 27'd21715617; 7'd38:  r = 27'd22333683;
            7'd39:  r = 27'd22954499; 7'd40:  r = 27'd23578178; 7'd41:  r = 27'd24204835;
            7'd42:  r = 27'd24834587; 7'd43:  r = 27'd25467560; 7'd44:  r = 27'd26103881;
            7'd45:  r = 27'd26743684; 7'd46:  r = 27'd27387108; 7'd47:  r = 27'd28034297;
            7'd48:  r = 27'd28685402; 7'd49:  r = 27'd29340582; 7'd50:  r = 27'd30000000;
            7'd51:  r = 27'd30663830; 7'd52:  r = 27'd31332251; 7'd53:  r = 27'd32005455;
            7'd54:  r = 27'd32683639; 7'd55:  r = 27'd33367013; 7'd56:  r = 27'd34055798;
            7'd57:  r = 27'd34750226; 7'd58:  r = 27'd35450543; 7'd59:  r = 27'd36157008;
            7'd60:  r = 27'd36869898; 7'd61:  r = 27'd37589503; 7'd62:  r = 27'd38316134;
            7'd63:  r = 27'd39050123; 7'd64:  r = 27'd39791819; 7'd65:  r = 27'd40541602;
            7'd66:  r = 27'd41299873; 7'd67:  r = 27'd42067065; 7'd68:  r = 27'd42843643;
            7'd69:  r = 27'd43630109; 7'd70:  r = 27'd44427004; 7'd71:  r = 27'd45234915;
            7'd72:  r = 27'd46054480; 7'd73:  r = 27'd46886394; 7'd74:  r = 27'd47731416;
            7'd75:  r = 27'd48590378; 7'd76:  r = 27'd49464198; 7'd77:  r = 27'd50353889;
            7'd78:  r = 27'd51260575; 7'd79:  r = 27'd52185511; 7'd80:  r = 27'd53130102;
            7'd81:  r = 27'd54095931; 7'd82:  r = 27'd55084794; 7'd83:  r = 27'd56098738;
            7'd84:  r = 27'd57140120; 7'd85:  r = 27'd58211669; 7'd86:  r = 27'd59316583;
            7'd87:  r = 27'd60458639; 7'd88:  r = 27'd61642363; 7'd89:  r = 27'd62873247;
            7'd90:  r = 27'd64158067; 7'd91:  r = 27'd65505352; 7'd92:  r = 27'd66926082;
            7'd93:  r = 27'd68434815; 7'd94:  r = 27'd70051556; 7'd95:  r = 27'd71805128;
            7'd96:  r = 27'd73739795; 7'd97:  r = 27'd75930132; 7'd98:  r = 27'd78521659;
            7'd99:  r = 27'd81890386; 7'd100: r = 27'd90000000;
            default: r = 27'd0;
        endcase
        return r;
    endfunction

endpackage

// ===== design/tkpd_if.sv =====
interface tkpd_in_if;
    logic        valid;
    logic        ready;
    logic [11:0] gravity_sample;
    logic [11:0] gyro_sample;

    modport source (output valid, output gravity_sample, output gyro_sample, input ready);
    modport sink   (input valid, input gravity_sample, input gyro_sample, output ready);
endinterface

interface tkpd_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] tilt_angle;
    logic signed [31:0] tilt_rate;
    logic signed [39:0] drive_value;

    modport source (output valid, output tilt_angle, output tilt_rate, output drive_value,
                    input ready);
    modport sink   (input valid, input tilt_angle, input tilt_rate, input drive_value,
                    output ready);
endinterface

// ===== design/tkpd_serial_arith.sv =====
// Bit-serial signed multiplier and rounding divider sharing one set of shift registers.
// The divider rounds only when rnd is set; done pulses for one cycle after the last iteration.
module tkpd_serial_arith
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  tkpd_pkg::tkpd_arith_req_t req,
    output tkpd_pkg::tkpd_arith_rsp_t rsp
);
    import tkpd_pkg::*;

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic               is_div_reg, is_div_next;
    logic               neg_reg, neg_next;
    logic [6:0]         cnt_reg, cnt_next;
    logic [OPA_W:0]     acc_reg, acc_next;
    logic [OPA_W-1:0]   mcand_reg, mcand_next;
    logic [OPB_W-1:0]   opb_reg, opb_next;
    logic [OPB_W-1:0]   rem_reg, rem_next;

    logic               a_neg, b_neg;
    logic [OPA_W-1:0]   a_mag;
    logic [OPB_W-1:0]   b_mag;
    logic [OPB_W:0]     trial;
    logic               fits;
    logic [OPA_W-1:0]   mag;

    always_comb
    begin
        a_neg = req.a[OPA_W-1];
        b_neg = req.b[OPB_W-1];
        a_mag = a_neg ? OPA_W'(-req.a) : OPA_W'(req.a);
        b_mag = b_neg ? OPB_W'(-req.b) : OPB_W'(req.b);
        trial = {rem_reg, acc_reg[OPA_W]};
        fits  = trial >= {1'b0, opb_reg};

        busy_next   = busy_reg;
        done_next   = 1'b0;
        is_div_next = is_div_reg;
        neg_next    = neg_reg;
        cnt_next    = cnt_reg;
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        opb_next    = opb_reg;
        rem_next    = rem_reg;

        if (req.start)
        begin
            busy_next   = 1'b1;
            is_div_next = req.is_div;
            opb_next    = b_mag;
            mcand_next  = a_mag;
            rem_next    = '0;
            if (req.is_div)
            begin
                // If rnd, adding half the divisor first makes the quotient round half away.
                neg_next = a_neg;
                cnt_next = 7'(OPA_W + 1);
                acc_next = {1'b0, a_mag} + (req.rnd ? (OPA_W+1)'(b_mag >> 1) : '0);
            end
            else
            begin
                neg_next = a_neg ^ b_neg;
                cnt_next = 7'(OPB_W);
                acc_next = '0;
            end
        end
        else if (busy_reg)
        begin
            if (is_div_reg)
            begin
                rem_next = fits ? OPB_W'(trial - {1'b0, opb_reg}) : OPB_W'(trial);
                acc_next = {acc_reg[OPA_W-1:0], fits};
            end
            else
            begin
                if (opb_reg[0])
                    acc_next = acc_reg + {1'b0, mcand_reg};
                mcand_next = {mcand_reg[OPA_W-2:0], 1'b0};
                opb_next   = {1'b0, opb_reg[OPB_W-1:1]};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end

        mag       = acc_reg[OPA_W-1:0];
        rsp.done  = done_reg;
        rsp.value = neg_reg ? $signed(-mag) : $signed(mag);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        is_div_reg <= is_div_next;
        neg_reg    <= neg_next;
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        opb_reg    <= opb_next;
        rem_reg    <= rem_next;
    end

endmodule

// ===== design/tilt_kalman_pd_controller.sv =====
// Tilt estimator and PD balance controller.
// A request on sample_ch carries one raw accelerometer and one raw gyro reading per
// control tick. The block scales both, looks the clamped accelerometer value up in an
// arcsine table, runs a two-state Kalman filter (angle and gyro bias) and forms a PD
// drive value; a request on result_ch then carries the filtered angle, the corrected
// rate and the saturated drive.
// The five tuning registers are written through cfg_we, cfg_index and cfg_data; the user
// must write them only while the block is idle, which the block itself does not enforce.
// A write to an unused index is ignored. One shared bit-serial unit does every multiply
// and divide, and the filter correction is skipped when the innovation variance is not
// positive. Samples are handled one at a time.
// The result sits in an output register, so the next sample is accepted while it waits;
// if the receiver still stalls when the following result is ready, the block holds that
// result and accepts nothing more until the register is free.
// Reset loads the tuning defaults, zeroes angle and bias and sets the covariance to the
// identity matrix.
module tilt_kalman_pd_controller
#(
    parameter int ADC_BITS  = 12,
    parameter int FRAC_BITS = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    tkpd_in_if.sink           sample_ch,
    tkpd_out_if.source        result_ch,
    input  logic              cfg_we,
    input  logic [2:0]        cfg_index,
    input  logic [13:0]       cfg_data
);
    import tkpd_pkg::*;

    // Only the low ADC_BITS bits of each sample, at most 12, are meaningful.
    localparam int          USED_BITS = (ADC_BITS < 12) ? ADC_BITS : 12;
    localparam logic [11:0] ADC_MASK  = 12'((64'd1 << USED_BITS) - 64'd1);
    localparam longint      QONE      = 64'sd1 << FRAC_BITS;
    // Measurement noise and the per-tick growth of the bias variance, in fixed point.
    localparam longint      MEAS_R    = (67 * QONE + 50) / 100;
    localparam longint      P11_STEP  = (3 * QONE + 100000) / 200000;
    localparam longint      DRV_DEN   = 10 * QONE;

    tkpd_state_t        state_reg, state_next;
    logic               issued_reg, issued_next;
    tkpd_arith_req_t    req;
    tkpd_arith_rsp_t    rsp;

    // Tuning registers.
    logic [13:0]        grav_off_reg, gyro_off_reg, gain_p_reg, gain_d_reg;
    logic signed [7:0]  zero_reg;

    // Filter state.
    logic signed [31:0] angle_reg, bias_reg;
    logic signed [31:0] p00_reg, p01_reg, p10_reg, p11_reg;

    // Per-sample working registers.
    logic [11:0]         grav_reg, gyro_reg;
    logic [6:0]          gd_mag_reg;
    logic                gd_neg_reg;
    logic signed [31:0]  meas_reg;
    logic signed [15:0]  wd_reg;
    logic signed [33:0]  e_reg;
    logic signed [32:0]  err_reg;
    logic signed [31:0]  rate_reg;
    logic signed [39:0]  drive_reg;
    logic signed [OPA_W-1:0] t_reg;

    // Output register.
    logic               out_valid_reg;
    logic signed [31:0] out_angle_reg, out_rate_reg;
    logic signed [39:0] out_drive_reg;

    logic signed [16:0]      diff_g, diff_w;
    logic signed [40:0]      gyro_q;
    logic signed [OPA_W-1:0] ten_angle, ten_rate, zero_q;
    logic signed [33:0]      e_next;
    logic                    out_free;
    logic [6:0]              gd_mag;
    logic signed [OPA_W-1:0] v;

    tkpd_serial_arith u_arith
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    assign v = rsp.value;

    always_comb
    begin
        diff_g    = $signed({5'b0, grav_reg & ADC_MASK}) - $signed({3'b0, grav_off_reg});
        diff_w    = $signed({5'b0, gyro_reg & ADC_MASK}) - $signed({3'b0, gyro_off_reg});
        gyro_q    = 41'(wd_reg) <<< FRAC_BITS;
        ten_angle = (OPA_W'(angle_reg) <<< 3) + (OPA_W'(angle_reg) <<< 1);
        ten_rate  = (OPA_W'(rate_reg) <<< 3) + (OPA_W'(rate_reg) <<< 1);
        zero_q    = OPA_W'(zero_reg) <<< FRAC_BITS;
        e_next    = 34'(MEAS_R) + 34'(p00_reg);
        out_free  = !out_valid_reg || result_ch.ready;

        // Clamp the scaled accelerometer value to the table range and split off its sign.
        if (v > OPA_W'(ASIN_HALF))
            gd_mag = 7'(ASIN_HALF);
        else if (v < -OPA_W'(ASIN_HALF))
            gd_mag = 7'(ASIN_HALF);
        else if (v < 0)
            gd_mag = 7'(-v);
        else
            gd_mag = v[6:0];
    end

    // Sequencer: each arithmetic state issues one operation and moves on when it is done.
    always_comb
    begin
        state_next  = state_reg;
        issued_next = issued_reg;
        req.start   = 1'b0;
        req.is_div  = 1'b0;
        req.rnd     = 1'b1;
        req.a       = '0;
        req.b       = '0;

        unique case (state_reg)
            ST_IDLE:     if (sample_ch.valid) state_next = ST_GD_MUL;
            ST_GD_MUL:   begin req.a = OPA_W'(diff_g); req.b = GRAV_NUM; end
            ST_GD_DIV:   begin req.is_div = 1'b1; req.rnd = 1'b0;
                               req.a = t_reg; req.b = SCALE_DEN; end
            ST_MEAS_DIV: begin req.is_div = 1'b1;
                               req.a = OPA_W'(asin_micro(gd_mag_reg)) <<< FRAC_BITS;
                               req.b = MICRO_DEN; end
            ST_WD_MUL:   begin req.a = OPA_W'(diff_w); req.b = GYRO_NUM; end
            ST_WD_DIV:   begin req.is_div = 1'b1; req.rnd = 1'b0;
                               req.a = t_reg; req.b = SCALE_DEN; end
            ST_ANG_DIV:  begin req.is_div = 1'b1;
                               req.a = OPA_W'(gyro_q) - OPA_W'(bias_reg); req.b = DT_DEN; end
            ST_P00_MUL:  begin req.a = OPA_W'(p01_reg) + OPA_W'(p10_reg); req.b = COV_MUL; end
            ST_P00_DIV:  begin req.is_div = 1'b1;
                               req.a = OPA_W'(QONE) - t_reg; req.b = NOISE_DEN; end
            ST_P01_DIV:  begin req.is_div = 1'b1; req.a = OPA_W'(p11_reg); req.b = DT_DEN; end
            ST_CHECK:    state_next = (e_next > 0) ? ST_KA_MUL : ST_RATE;
            ST_KA_MUL:   begin req.a = OPA_W'(p00_reg); req.b = OPB_W'(err_reg); end
            ST_KB_MUL:   begin req.a = OPA_W'(p10_reg); req.b = OPB_W'(err_reg); end
            ST_K11_MUL:  begin req.a = OPA_W'(p10_reg); req.b = OPB_W'(p01_reg); end
            ST_K10_MUL:  begin req.a = OPA_W'(p10_reg); req.b = OPB_W'(p00_reg); end
            ST_K01_MUL:  begin req.a = OPA_W'(p00_reg); req.b = OPB_W'(p01_reg); end
            ST_K00_MUL:  begin req.a = OPA_W'(p00_reg); req.b = OPB_W'(p00_reg); end
            ST_KA_DIV, ST_KB_DIV, ST_K11_DIV, ST_K10_DIV, ST_K01_DIV, ST_K00_DIV:
                         begin req.is_div = 1'b1; req.a = t_reg; req.b = e_reg; end
            ST_RATE:     state_next = ST_DP_MUL;
            ST_DP_MUL:   begin req.a = ten_angle - zero_q; req.b = {20'b0, gain_p_reg}; end
            ST_DD_MUL:   begin req.a = ten_rate; req.b = {20'b0, gain_d_reg}; end
            ST_DRV_DIV:  begin req.is_div = 1'b1;
                               req.a = t_reg <<< 8; req.b = OPB_W'(DRV_DEN); end
            ST_OUT:      if (out_free) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase

        if (state_reg != ST_IDLE && state_reg != ST_CHECK && state_reg != ST_RATE &&
            state_reg != ST_OUT)
        begin
            req.start   = !issued_reg;
            issued_next = 1'b1;
            if (rsp.done)
            begin
                issued_next = 1'b0;
                unique case (state_reg)
                    ST_GD_MUL:   state_next = ST_GD_DIV;
                    ST_GD_DIV:   state_next = ST_MEAS_DIV;
                    ST_MEAS_DIV: state_next = ST_WD_MUL;
                    ST_WD_MUL:   state_next = ST_WD_DIV;
                    ST_WD_DIV:   state_next = ST_ANG_DIV;
                    ST_ANG_DIV:  state_next = ST_P00_MUL;
                    ST_P00_MUL:  state_next = ST_P00_DIV;
                    ST_P00_DIV:  state_next = ST_P01_DIV;
                    ST_P01_DIV:  state_next = ST_CHECK;
                    ST_KA_MUL:   state_next = ST_KA_DIV;
                    ST_KA_DIV:   state_next = ST_KB_MUL;
                    ST_KB_MUL:   state_next = ST_KB_DIV;
                    ST_KB_DIV:   state_next = ST_K11_MUL;
                    ST_K11_MUL:  state_next = ST_K11_DIV;
                    ST_K11_DIV:  state_next = ST_K10_MUL;
                    ST_K10_MUL:  state_next = ST_K10_DIV;
                    ST_K10_DIV:  state_next = ST_K01_MUL;
                    ST_K01_MUL:  state_next = ST_K01_DIV;
                    ST_K01_DIV:  state_next = ST_K00_MUL;
                    ST_K00_MUL:  state_next = ST_K00_DIV;
                    ST_K00_DIV:  state_next = ST_RATE;
                    ST_DP_MUL:   state_next = ST_DD_MUL;
                    ST_DD_MUL:   state_next = ST_DRV_DIV;
                    ST_DRV_DIV:  state_next = ST_OUT;
                    default:     state_next = ST_IDLE;
                endcase
            end
        end
    end

    assign sample_ch.ready       = (state_reg == ST_IDLE);
    assign result_ch.valid       = out_valid_reg;
    assign result_ch.tilt_angle  = out_angle_reg;
    assign result_ch.tilt_rate   = out_rate_reg;
    assign result_ch.drive_value = out_drive_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            issued_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            grav_off_reg  <= 14'd1850;
            gyro_off_reg  <= 14'd980;
            zero_reg      <= -8'sd10;
            gain_p_reg    <= 14'd1400;
            gain_d_reg    <= 14'd6;
            angle_reg     <= '0;
            bias_reg      <= '0;
            p00_reg       <= 32'(QONE);
            p01_reg       <= '0;
            p10_reg       <= '0;
            p11_reg       <= 32'(QONE);
        end
        else
        begin
            state_reg  <= state_next;
            issued_reg <= issued_next;

            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_GRAVITY_OFFSET: grav_off_reg <= cfg_data;
                    REG_GYRO_OFFSET:    gyro_off_reg <= cfg_data;
                    REG_ANGLE_ZERO:     zero_reg     <= $signed(cfg_data[7:0]);
                    REG_GAIN_P:         gain_p_reg   <= cfg_data;
                    REG_GAIN_D:         gain_d_reg   <= cfg_data;
                    default:            ;
                endcase
            end

            if (state_reg == ST_OUT && out_free)
                out_valid_reg <= 1'b1;
            else if (result_ch.ready)
                out_valid_reg <= 1'b0;

            // Every new state value saturates at the 32-bit limits.
            if (rsp.done)
            begin
                unique case (state_reg)
                    ST_ANG_DIV: angle_reg <= sat32(OPA_W'(angle_reg) + v);
                    ST_P00_DIV: p00_reg   <= sat32(OPA_W'(p00_reg) + v);
                    ST_P01_DIV:
                    begin
                        p01_reg <= sat32(OPA_W'(p01_reg) - v);
                        p10_reg <= sat32(OPA_W'(p10_reg) - v);
                        p11_reg <= sat32(OPA_W'(p11_reg) + OPA_W'(P11_STEP));
                    end
                    ST_KA_DIV:  angle_reg <= sat32(OPA_W'(angle_reg) + v);
                    ST_KB_DIV:  bias_reg  <= sat32(OPA_W'(bias_reg) + v);
                    ST_K11_DIV: p11_reg   <= sat32(OPA_W'(p11_reg) - v);
                    ST_K10_DIV: p10_reg   <= sat32(OPA_W'(p10_reg) - v);
                    ST_K01_DIV: p01_reg   <= sat32(OPA_W'(p01_reg) - v);
                    ST_K00_DIV: p00_reg   <= sat32(OPA_W'(p00_reg) - v);
                    default:    ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_ch.valid && state_reg == ST_IDLE)
        begin
            grav_reg <= sample_ch.gravity_sample;
            gyro_reg <= sample_ch.gyro_sample;
        end

        if (state_reg == ST_CHECK)
        begin
            e_reg   <= e_next;
            err_reg <= 33'(meas_reg) - 33'(angle_reg);
        end

        if (state_reg == ST_RATE)
            rate_reg <= sat32(OPA_W'(gyro_q) - OPA_W'(bias_reg));

        // The whole result moves into the output register together, so a waiting
        // result is never disturbed by the sample behind it.
        if (state_reg == ST_OUT && out_free)
        begin
            out_angle_reg <= angle_reg;
            out_rate_reg  <= rate_reg;
            out_drive_reg <= drive_reg;
        end

        if (rsp.done)
        begin
            unique case (state_reg)
                ST_GD_MUL, ST_WD_MUL, ST_P00_MUL, ST_DP_MUL,
                ST_KA_MUL, ST_KB_MUL, ST_K11_MUL, ST_K10_MUL, ST_K01_MUL, ST_K00_MUL:
                    t_reg <= v;
                ST_DD_MUL:   t_reg <= t_reg + v;
                ST_GD_DIV:
                begin
                    gd_mag_reg <= gd_mag;
                    gd_neg_reg <= v < 0;
                end
                ST_MEAS_DIV: meas_reg <= gd_neg_reg ? -v[31:0] : v[31:0];
                ST_WD_DIV:   wd_reg   <= v[15:0];
                ST_DRV_DIV:  drive_reg <= sat40(v);
                default:     ;
            endcase
        end
    end

endmodule

// ===== sim/tilt_kalman_pd_controller_test.sv =====
`timescale 1ns / 100ps

module tilt_kalman_pd_controller_test;
    import tkpd_pkg::*;

    // Fixed-point scale of the filter state.
    localparam longint QONE = 64'sd65536;
    // Register indexes beyond the five tuning registers; writes there must be ignored.
    localparam logic [2:0] REG_UNUSED_A = 3'd5;
    localparam logic [2:0] REG_UNUSED_B = 3'd7;
    // Cycles with no request accepted on either channel before the run is abandoned.
    // The limit covers the slowest sample plus the stalls of both sides.
    localparam int IDLE_LIMIT = 20000;
    localparam int RANDOM_ITEMS = 1100;
    localparam int PHASES = 6;

    typedef struct packed {
        logic signed [31:0] angle;
        logic signed [31:0] rate;
        logic signed [39:0] drive;
    } tilt_result_t;

    typedef struct {
        logic [11:0]  gravity;
        logic [11:0]  gyro;
        bit           known;
        tilt_result_t result;
    } sample_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [13:0] cfg_data = '0;

    tkpd_in_if  sample_ch ();
    tkpd_out_if result_ch ();

    tilt_kalman_pd_controller dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample_ch (sample_ch.sink),
        .result_ch (result_ch.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    // Arcsine of 0.00 to 1.00 in steps of 0.01, in micro-degrees.
    const int asin_ud [0:100] = '{
        0, 572967, 1145992, 1719131, 2292443, 2865984, 3439813, 4013987, 4588566, 5163607,
        5739170, 6315316, 6892103, 7469592, 8047846, 8626927, 9206896, 9787819, 10369760,
        10952784, 11536959, 12122352, 12709033, 13297072, 13886540, 14477512, 15070062,
        15664267, 16260205, 16857956, 17457603, 18059230, 18662925, 19268775, 19876874,
        20487315, 21100196, 21715617, 22333683, 22954499, 23578178, 24204835, 24834587,
        25467560, 26103881, 26743684, 27387108, 28034297, 28685402, 29340582, 30000000,
        30663830, 31332251, 32005455, 32683639, 33367013, 34055798, 34750226, 35450543,
        36157008, 36869898, 37589503, 38316134, 39050123, 39791819, 40541602, 41299873,
        42067065, 42843643, 43630109, 44427004, 45234915, 46054480, 46886394, 47731416,
        48590378, 49464198, 50353889, 51260575, 52185511, 53130102, 54095931, 55084794,
        56098738, 57140120, 58211669, 59316583, 60458639, 61642363, 62873247, 64158067,
        65505352, 66926082, 68434815, 70051556, 71805128, 73739795, 75930132, 78521659,
        81890386, 90000000
    };

    // The testbench's own copy of the tuning registers and of the filter state.
    longint grav_off, gyro_off, zero_tenths, gain_p, gain_d;
    longint est_angle, est_bias;
    longint cov [4];

    tilt_result_t pending_results [$];   // results still owed by the block
    bit           row_known [$];         // per sent sample: typed-in result present
    tilt_result_t row_result [$];
    int           failures = 0;
    int           samples_in = 0;
    int           results_out = 0;
    int           idle_cycles = 0;
    bit           rx_no_stall = 1'b0;
    bit           tx_no_gap = 1'b0;

    function automatic longint div_round(longint n, longint d);
        longint h;
        h = d / 2;
        if (n >= 0)
            return (n + h) / d;
        return -((-n + h) / d);
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint clamp40(longint v);
        if (v > 64'sd549755813887)
            return 64'sd549755813887;
        if (v < -64'sd549755813888)
            return -64'sd549755813888;
        return v;
    endfunction

    task automatic reset_model();
        grav_off = 1850;
        gyro_off = 980;
        zero_tenths = -10;
        gain_p = 1400;
        gain_d = 6;
        est_angle = 0;
        est_bias = 0;
        cov[0] = QONE;
        cov[1] = 0;
        cov[2] = 0;
        cov[3] = QONE;
    endtask

    task automatic write_model_reg(logic [2:0] idx, logic [13:0] data);
        case (idx)
            REG_GRAVITY_OFFSET: grav_off = longint'(data);
            REG_GYRO_OFFSET:    gyro_off = longint'(data);
            REG_ANGLE_ZERO:     zero_tenths = longint'($signed(data[7:0]));
            REG_GAIN_P:         gain_p = longint'(data);
            REG_GAIN_D:         gain_d = longint'(data);
            default: ;
        endcase
    endtask

    // One control tick of the estimator: prediction, correction and PD drive.
    function automatic tilt_result_t tick_filter(logic [11:0] g, logic [11:0] y);
        longint gd, wd, mag, meas, gq, a, bias, e, err, rate, num;
        longint p00, p01, p10, p11, n00, n01, n10, n11;
        tilt_result_t r;
        gd = (longint'(g) - grav_off) * 1242 / 10000;
        if (gd > ASIN_HALF)
            gd = ASIN_HALF;
        if (gd < -ASIN_HALF)
            gd = -ASIN_HALF;
        mag = (gd < 0) ? -gd : gd;
        meas = div_round(longint'(asin_ud[mag]) * QONE, 1000000);
        if (gd < 0)
            meas = -meas;
        wd = (longint'(y) - gyro_off) * 2357 / 10000;
        gq = wd * QONE;

        bias = est_bias;
        a = clamp32(est_angle + div_round(gq - bias, 200));
        p00 = clamp32(cov[0] + div_round(QONE - 1000 * (cov[1] + cov[2]), 200000));
        p01 = clamp32(cov[1] - div_round(cov[3], 200));
        p10 = clamp32(cov[2] - div_round(cov[3], 200));
        p11 = clamp32(cov[3] + div_round(3 * QONE, 200000));

        // The correction is skipped when the innovation variance is not positive.
        e = div_round(67 * QONE, 100) + p00;
        if (e > 0)
        begin
            err = meas - a;
            a = clamp32(a + div_round(p00 * err, e));
            bias = clamp32(bias + div_round(p10 * err, e));
            n00 = clamp32(p00 - div_round(p00 * p00, e));
            n01 = clamp32(p01 - div_round(p00 * p01, e));
            n10 = clamp32(p10 - div_round(p10 * p00, e));
            n11 = clamp32(p11 - div_round(p10 * p01, e));
            p00 = n00;
            p01 = n01;
            p10 = n10;
            p11 = n11;
        end
        est_angle = a;
        est_bias = bias;
        cov[0] = p00;
        cov[1] = p01;
        cov[2] = p10;
        cov[3] = p11;

        rate = clamp32(gq - bias);
        num = ((10 * a - zero_tenths * QONE) * gain_p + 10 * rate * gain_d) * 256;
        r.angle = a[31:0];
        r.rate = rate[31:0];
        r.drive = clamp40(div_round(num, 10 * QONE));
        return r;
    endfunction

    // Everything is observed at the rising edge: register writes and requests on both
    // channels update the model and the scoreboard in the order they happen.
    always @(posedge clk)
    begin
        tilt_result_t exp_r;
        tilt_result_t got;
        bit known;
        bit seen;
        if (rst_n)
        begin
            seen = 1'b0;
            if (cfg_we)
                write_model_reg(cfg_index, cfg_data);
            if (sample_ch.valid && sample_ch.ready)
            begin
                seen = 1'b1;
                samples_in++;
                exp_r = tick_filter(sample_ch.gravity_sample, sample_ch.gyro_sample);
                known = row_known.pop_front();
                got = row_result.pop_front();
                // Rows with a typed-in result are held to that value rather than the model.
                pending_results.push_back(known ? got : exp_r);
            end
            if (result_ch.valid && result_ch.ready)
            begin
                seen = 1'b1;
                results_out++;
                if (pending_results.size() == 0)
                begin
                    $error("result with nothing expected: angle %0d rate %0d drive %0d",
                           result_ch.tilt_angle, result_ch.tilt_rate, result_ch.drive_value);
                    failures++;
                end
                else
                begin
                    exp_r = pending_results.pop_front();
                    if (result_ch.tilt_angle !== exp_r.angle)
                    begin
                        $error("tilt_angle expected %0d got %0d", exp_r.angle,
                               result_ch.tilt_angle);
                        failures++;
                    end
                    if (result_ch.tilt_rate !== exp_r.rate)
                    begin
                        $error("tilt_rate expected %0d got %0d", exp_r.rate,
                               result_ch.tilt_rate);
                        failures++;
                    end
                    if (result_ch.drive_value !== exp_r.drive)
                    begin
                        $error("drive_value expected %0d got %0d", exp_r.drive,
                               result_ch.drive_value);
                        failures++;
                    end
                end
            end
            idle_cycles <= seen ? 0 : idle_cycles + 1;
        end
    end

    // Watchdog: a stuck handshake on either side ends the run.
    always @(posedge clk)
    begin
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("timeout after %0d quiet cycles", idle_cycles);
            $display("tilt_kalman_pd_controller_test: FAIL");
            $finish;
        end
    end

    // The receiver stalls a random number of cycles before each result, except in
    // stretches where it takes every result at once.
    initial
    begin
        int stall;
        result_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            stall = rx_no_stall ? 0 : $urandom_range(0, 19);
            if (stall > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            result_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(result_ch.valid && result_ch.ready));
        end
    end

    task automatic send_sample(logic [11:0] g, logic [11:0] y, bit known, tilt_result_t r);
        int gap;
        gap = tx_no_gap ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        row_known.push_back(known);
        row_result.push_back(r);
        sample_ch.gravity_sample <= g;
        sample_ch.gyro_sample <= y;
        sample_ch.valid <= 1'b1;
        do
            @(posedge clk);
        while (!(sample_ch.valid && sample_ch.ready));
        @(negedge clk);
    endtask

    // Register writes happen only once every owed result has been taken.
    task automatic write_reg(logic [2:0] idx, logic [13:0] data);
        sample_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic write_tuning(int goff, int yoff, int tenths, int kp, int kd);
        logic [7:0] t8;
        t8 = tenths[7:0];
        write_reg(REG_GRAVITY_OFFSET, goff[13:0]);
        write_reg(REG_GYRO_OFFSET, yoff[13:0]);
        write_reg(REG_ANGLE_ZERO, {6'd0, t8});
        write_reg(REG_GAIN_P, kp[13:0]);
        write_reg(REG_GAIN_D, kd[13:0]);
    endtask

    // Random sample near the configured offsets, so the filter tracks a plausible tilt,
    // or now and then anywhere in the ADC range.
    function automatic logic [11:0] near_offset(longint off, int spread);
        longint v;
        if ($urandom_range(0, 9) == 0)
            return 12'($urandom_range(0, 4095));
        v = off + longint'($urandom_range(0, 2 * spread)) - spread;
        if (v < 0)
            v = 0;
        if (v > 4095)
            v = 4095;
        return v[11:0];
    endfunction

    initial
    begin
        sample_row_t  table_rows [$];
        tilt_result_t none;
        int           per_phase;
        int           spread;
        int           goff, yoff;

        none = '0;
        reset_model();
        sample_ch.valid = 1'b0;
        sample_ch.gravity_sample = '0;
        sample_ch.gyro_sample = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part. The first row sits exactly on both reset offsets: level, no
        // rotation, so only the setpoint term of the drive remains.
        table_rows.push_back('{12'd1850, 12'd980, 1'b1, '{32'sd0, 32'sd0, 40'sd358400}});
        table_rows.push_back('{12'd0, 12'd0, 1'b0, none});          // offsets above sample
        table_rows.push_back('{12'd4095, 12'd4095, 1'b0, none});    // scaled value beyond +100
        table_rows.push_back('{12'd0, 12'd4095, 1'b0, none});
        table_rows.push_back('{12'd4095, 12'd0, 1'b0, none});
        table_rows.push_back('{12'd1850, 12'd980, 1'b0, none});
        table_rows.push_back('{12'd2655, 12'd980, 1'b0, none});     // scaled value 99, just short of +100
        table_rows.push_back('{12'd1045, 12'd980, 1'b0, none});     // scaled value -99, just short of -100
        table_rows.push_back('{12'd1858, 12'd984, 1'b0, none});     // small positive
        table_rows.push_back('{12'd1842, 12'd976, 1'b0, none});     // small negative
        table_rows.push_back('{12'd2730, 12'd1555, 1'b0, none});
        table_rows.push_back('{12'd1365, 12'd2730, 1'b0, none});
        foreach (table_rows[i])
            send_sample(table_rows[i].gravity, table_rows[i].gyro, table_rows[i].known,
                        table_rows[i].result);

        // Writes to unused indexes must change nothing; the following rows check that.
        write_reg(REG_UNUSED_A, 14'h3FFF);
        write_reg(REG_UNUSED_B, 14'h2AAA);
        send_sample(12'd1850, 12'd980, 1'b0, none);
        send_sample(12'd4095, 12'd0, 1'b0, none);

        // Extremes of every register: zero offsets and gains, then the largest values,
        // which drive the gyro rate and the drive towards saturation.
        write_tuning(0, 0, -99, 0, 0);
        send_sample(12'd0, 12'd0, 1'b0, none);
        send_sample(12'd4095, 12'd4095, 1'b0, none);
        send_sample(12'd800, 12'd4095, 1'b0, none);
        write_tuning(9999, 9999, 99, 9999, 9999);
        send_sample(12'd0, 12'd0, 1'b0, none);
        send_sample(12'd4095, 12'd4095, 1'b0, none);
        send_sample(12'd0, 12'd4095, 1'b0, none);

        // Random part in phases, each with its own tuning; the first phase goes back to
        // the reset values, the second and fifth use extremes again, the others random values.
        per_phase = RANDOM_ITEMS / PHASES;
        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0: write_tuning(1850, 980, -10, 1400, 6);
                1: write_tuning(0, 4095, 0, 9999, 0);
                4: write_tuning(9999, 0, -99, 9999, 9999);
                default:
                begin
                    goff = $urandom_range(200, 3900);
                    yoff = $urandom_range(200, 3900);
                    write_tuning(goff, yoff, $urandom_range(0, 198) - 99,
                                 $urandom_range(0, 9999), $urandom_range(0, 9999));
                end
            endcase
            for (int i = 0; i < per_phase; i++)
            begin
                // Some stretches run with no idling on one side or both.
                if (i % 60 == 0)
                begin
                    tx_no_gap = ($urandom_range(0, 3) == 0);
                    rx_no_stall = ($urandom_range(0, 3) == 0);
                end
                spread = ($urandom_range(0, 1) == 0) ? 40 : 900;
                send_sample(near_offset(grav_off, spread), near_offset(gyro_off, spread),
                            1'b0, none);
            end
        end
        sample_ch.valid <= 1'b0;
        rx_no_stall = 1'b0;

        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (1500) @(negedge clk);

        $display("covered %0d samples and %0d results over %0d tuning settings,",
                 samples_in, results_out, PHASES + 3);
        $display("including offset, gain and setpoint extremes and saturated inputs");
        if (failures == 0 && pending_results.size() == 0)
            $display("tilt_kalman_pd_controller_test: PASS");
        else
            $display("tilt_kalman_pd_controller_test: FAIL");
        $finish;
    end

endmodule
